// ----- design/gaussian_blur_3x3_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gaussian_blur_3x3_core project
// Shared wrappers for clocked concurrent checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_CORE_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define GB3_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence must hold in the same cycle as the antecedent.
`define GB3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define GB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gb3_pkg.sv -----
// ----------------------------------------------------------------------------
// gb3_pkg
// Widths, register codes and shared types of the 3x3 Gaussian blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

   // Field widths
   localparam int PIXEL_W      = 8;
   localparam int RESULT_W     = 12;
   localparam int VSUM_W       = 10;   // top + 2*middle + bottom, at most 1020
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;

   // Geometry
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MIN_DIM           = 3;

   // Window: number of column cells holding columns c-1 and c-2
   localparam int WINDOW_TAPS = 2;

   // Result queue depth: one result on display, two in the pipeline stages
   // and one more accepted in the same cycle
   localparam int FIFO_DEPTH = 4;

   // Control word that travels with a pixel through the pipeline
   typedef struct packed {
      logic valid;       // stage holds a pixel transaction
      logic produce;     // pixel completes an interior window
      logic frame_end;   // result is the last interior one of the frame
   } gb3_ctrl_type;

endpackage

`default_nettype wire

// ----- design/gb3_channels_if.sv -----
// ----------------------------------------------------------------------------
// gb3 stream channels
// Valid/ready channels for source pixels and blurred results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gb3_req_if;
   import gb3_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface gb3_rsp_if;
   import gb3_pkg::*;

   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] filtered_value;
   logic                frame_end;

   modport source (output valid, output filtered_value, output frame_end, input ready);
   modport sink   (input valid, input filtered_value, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/gb3_line_buffer.sv -----
// ----------------------------------------------------------------------------
// gb3_line_buffer
// Two-row line memory, one word per column holding {upper, middle} pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_buffer #(
   parameter int DEPTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [2*gb3_pkg::PIXEL_W-1:0]    rd_data,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [2*gb3_pkg::PIXEL_W-1:0]    wr_data
);
   import gb3_pkg::*;

   logic [2*PIXEL_W-1:0] mem_ff [DEPTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   // Write the rotated column word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/gb3_cell.sv -----
// ----------------------------------------------------------------------------
// gb3_cell
// One window column cell: holds a column sum and hands it to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_cell #(
   parameter int DATA_W = gb3_pkg::VSUM_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [DATA_W-1:0] column_sum,
   output      logic [DATA_W-1:0] data_out
);
   import gb3_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Take the neighbor's column when the window moves, else hold
   assign data_in = advance ? column_sum : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ----- design/gb3_window.sv -----
// ----------------------------------------------------------------------------
// gb3_window
// Chain of column cells and the 1-2-1 horizontal weighting of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_window (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire gb3_pkg::gb3_ctrl_type        ctrl_in,
   input  wire logic [gb3_pkg::VSUM_W-1:0]   vsum_in,
   output      gb3_pkg::gb3_ctrl_type        result_ctrl,
   output      logic [gb3_pkg::RESULT_W-1:0] result_value
);
   import gb3_pkg::*;

   // tap[0] is the incoming column, tap[k+1] the output of cell k (column c-1-k)
   logic [VSUM_W-1:0] tap [WINDOW_TAPS+1];

   assign tap[0] = vsum_in;

   // Shift the column chain on every pixel transaction
   for (genvar k = 0; k < WINDOW_TAPS; k++) begin : g_cell
      gb3_cell #(
         .DATA_W(VSUM_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (ctrl_in.valid),
         .column_sum (tap[k]),
         .data_out   (tap[k+1])
      );
   end

   // Weight columns c-2, c-1, c as 1, 2, 1
   assign result_value = RESULT_W'(tap[2]) + (RESULT_W'(tap[1]) << 1) + RESULT_W'(tap[0]);

   always_comb begin
      result_ctrl           = ctrl_in;
      result_ctrl.valid     = ctrl_in.valid && ctrl_in.produce;
   end

endmodule

`default_nettype wire

// ----- design/gaussian_blur_3x3_core.sv -----
// Pipeline: a pixel passes the line memory read, the column sum and the window
//   sum into the result queue before its result is shown.
// Throughput: one pixel per cycle, set by one read and one write of the line
//   memory a cycle and the column cell chain; ready drops only when the 4-entry
//   result queue is booked.
// Reset: synchronous; clears positions, window cells and queue, restores
//   width and height to 1024. Line memory contents are not cleared.
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_core
// Streaming 3x3 Gaussian blur with 1-2-1 by 1-2-1 kernel over raster pixels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_blur_3x3_core_macros.svh"

module gaussian_blur_3x3_core #(
   parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   gb3_req_if.sink                               req_chan,
   gb3_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [gb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gb3_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import gb3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int RW = $clog2(FIFO_DEPTH + 3);

   // ---------------------------------------------------------------- config
   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic                    csr_hit;

   assign csr_hit = csr_write_enable &&
                    (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT);

   // Decode register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_write_data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_write_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp geometry to its working range
   logic [EW-1:0]           width_ext, eff_width;
   logic [HEIGHT_REG_W-1:0] eff_height;

   assign width_ext  = EW'(width_ff);
   assign eff_width  = (width_ext < EW'(MIN_DIM))   ? EW'(MIN_DIM)   :
                       (width_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : width_ext;
   assign eff_height = (height_ff < HEIGHT_REG_W'(MIN_DIM)) ? HEIGHT_REG_W'(MIN_DIM)
                                                            : height_ff;

   // -------------------------------------------------------------- position
   logic [AW-1:0]           col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;
   logic                    col_last, row_last, accept;
   gb3_ctrl_type            acc_ctrl;

   assign col_last = (EW'(col_ff) == eff_width - EW'(1));
   assign row_last = (row_ff == eff_height - HEIGHT_REG_W'(1));
   assign accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      acc_ctrl.valid     = accept;
      acc_ctrl.produce   = (row_ff >= HEIGHT_REG_W'(2)) && (col_ff >= AW'(2));
      acc_ctrl.frame_end = row_last && col_last;
   end

   // Restart on a register write, else advance in raster order
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + HEIGHT_REG_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ----------------------------------------------------- stage 1: line read
   gb3_ctrl_type          s1_ctrl_ff;
   logic [PIXEL_W-1:0]    s1_pixel_ff;
   logic [AW-1:0]         s1_col_ff;
   logic [2*PIXEL_W-1:0]  line_rd_data;
   logic [PIXEL_W-1:0]    upper_px, middle_px;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= acc_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_chan.pixel;
         s1_col_ff   <= col_ff;
      end
   end

   // Read rows r-2 and r-1 at accept, rotate them one stage later
   gb3_line_buffer #(
      .DEPTH(MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd_data),
      .wr_en   (s1_ctrl_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data ({line_rd_data[PIXEL_W-1:0], s1_pixel_ff})
   );

   assign upper_px  = line_rd_data[2*PIXEL_W-1:PIXEL_W];
   assign middle_px = line_rd_data[PIXEL_W-1:0];

   // ---------------------------------------------------- stage 2: column sum
   gb3_ctrl_type      s2_ctrl_ff;
   logic [VSUM_W-1:0] s2_vsum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ctrl_ff.valid) begin
         s2_vsum_ff <= VSUM_W'(upper_px) + (VSUM_W'(middle_px) << 1) + VSUM_W'(s1_pixel_ff);
      end
   end

   // ------------------------------------------------------ window and sum
   gb3_ctrl_type        win_ctrl;
   logic [RESULT_W-1:0] win_value;

   gb3_window u_window (
      .clock        (clock),
      .reset        (reset),
      .ctrl_in      (s2_ctrl_ff),
      .vsum_in      (s2_vsum_ff),
      .result_ctrl  (win_ctrl),
      .result_value (win_value)
   );

   // ---------------------------------------------------------- result queue
   logic [RESULT_W-1:0] fifo_value_ff [FIFO_DEPTH];
   logic                fifo_end_ff   [FIFO_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [RW-1:0]       pending, booked;
   logic                push, pop;

   assign push = win_ctrl.valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   // Book a queue slot for every interior pixel still in the pipeline
   assign pending = RW'(s1_ctrl_ff.valid && s1_ctrl_ff.produce) +
                    RW'(s2_ctrl_ff.valid && s2_ctrl_ff.produce);
   assign booked  = RW'(count_ff) + pending;
   assign req_chan.ready = (booked < RW'(FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_value_ff[wr_ptr_ff] <= win_value;
         fifo_end_ff[wr_ptr_ff]   <= win_ctrl.frame_end;
      end
   end

   assign rsp_chan.valid          = (count_ff != '0);
   assign rsp_chan.filtered_value = fifo_value_ff[rd_ptr_ff];
   assign rsp_chan.frame_end      = fifo_end_ff[rd_ptr_ff];

   // ------------------------------------------------------------ assertions
   `GB3_ASSERT_ALWAYS(a_queue_booking, clock, reset, booked <= RW'(FIFO_DEPTH), "queue overbooked")
   `GB3_ASSERT_IMPL(a_push_has_room, clock, reset, push, count_ff < CW'(FIFO_DEPTH) || pop, "push into full queue")
   `GB3_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && row_last && col_last, col_ff == '0 && row_ff == '0, "frame did not wrap")
   `GB3_ASSERT_NEXT(a_csr_restart, clock, reset, csr_hit, col_ff == '0 && row_ff == '0, "register write did not restart frame")

endmodule

`default_nettype wire
